/* rtl/crc16_packet_checker_with_handshake_macros.svh */
`ifndef CRC16_PACKET_CHECKER_WITH_HANDSHAKE_MACROS_SVH
`define CRC16_PACKET_CHECKER_WITH_HANDSHAKE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while reset is low.
`define CPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while reset is low.
`define CPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cpc_pkg.sv */
package cpc_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] MAGIC_RESET    = 16'h5AA5;
  localparam logic [15:0] INTERVAL_RESET = 16'd1000;
  localparam logic [15:0] GREET_LEN      = 16'd12;
  localparam logic [15:0] HDR_BYTES      = 16'd6;
  localparam logic [15:0] CRC_BYTES      = 16'd2;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef enum logic [2:0] {
    V_ACCEPT  = 3'd0,
    V_IGNORED = 3'd1,
    V_DROPPED = 3'd2,
    V_GOOD    = 3'd3,
    V_SHORT   = 3'd4,
    V_MAGIC   = 3'd5,
    V_SIZE    = 3'd6,
    V_CRC     = 3'd7
  } verdict_t;

  typedef enum logic [0:0] {
    CFG_EXPECTED_MAGIC = 1'b0,
    CFG_STATS_INTERVAL = 1'b1
  } cfg_index_t;

  // Expected greeting character at a given position ("Hello Device").
  function automatic logic [7:0] greet_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h48;
      4'd1:    ch = 8'h65;
      4'd2:    ch = 8'h6C;
      4'd3:    ch = 8'h6C;
      4'd4:    ch = 8'h6F;
      4'd5:    ch = 8'h20;
      4'd6:    ch = 8'h44;
      4'd7:    ch = 8'h65;
      4'd8:    ch = 8'h76;
      4'd9:    ch = 8'h69;
      4'd10:   ch = 8'h63;
      4'd11:   ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // One byte through the reflected CRC-16, least significant bit first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/cpc_if.sv */
interface cpc_in_if import cpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface cpc_out_if import cpc_pkg::*; ();
  logic        valid;
  logic        ready;
  verdict_t    verdict;
  logic [31:0] total_count;
  logic [31:0] good_count;
  logic [31:0] bad_count;
  logic        stats_due;

  modport source (output valid, output verdict, output total_count, output good_count,
                  output bad_count, output stats_due, input ready);
  modport sink   (input valid, input verdict, input total_count, input good_count,
                  input bad_count, input stats_due, output ready);
endinterface

/* rtl/crc16_packet_checker_with_handshake.sv */
// Packet checker: takes one received word (a byte and its last-byte mark) per cycle on in_if
// while input is not held off, and gives one result word on out_if for every packet from the
// result register once its last word has left the input register. The sustained rate is one
// word per cycle; it is set by the processing stage, which does the byte-wide CRC-16 update
// (reflected 0x8408, init 0xFFFF), the header compares and the 32-bit counter increments in
// combinational logic between the input register and the result register. Until a packet
// starting with the greeting "Hello Device" arrives, packets are answered as ignored; after
// it, repeated greetings are dropped and every other packet is checked for length, magic,
// length field and trailing little-endian CRC, and counted. The result register is backed
// by a ready chain, so input is only held off while a finished result is still waiting and
// the next packet end arrives. Configuration writes on cfg_* must be done while no packet
// is in flight; a write of the interval restarts the statistics countdown.
`include "crc16_packet_checker_with_handshake_macros.svh"

module crc16_packet_checker_with_handshake import cpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  cpc_in_if.sink          in_if,
  cpc_out_if.source       out_if,
  input  logic            cfg_we,
  input  cfg_index_t      cfg_index,
  input  logic [15:0]     cfg_wdata
);

  // Configuration
  logic [15:0] magic_cfg_r;
  logic [15:0] interval_cfg_r;

  // Input register
  logic        s_valid_r;
  logic [7:0]  s_byte_r;
  logic        s_last_r;

  // Per-packet state
  logic        test_phase_r, test_phase_nxt;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  d0_r, d1_r;
  logic [15:0] hdr_magic_r, hdr_magic_nxt;
  logic [15:0] hdr_len_r, hdr_len_nxt;
  logic        greet_ok_r, greet_ok_nxt;

  // Statistics
  logic [31:0] total_r, total_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [15:0] countdown_r, countdown_nxt;

  // Result register
  logic        out_valid_r;
  verdict_t    out_verdict_r;
  logic [31:0] out_total_r;
  logic [31:0] out_good_r;
  logic [31:0] out_bad_r;
  logic        out_due_r;

  logic        out_free;
  logic        proc_go;
  logic        pkt_end;
  logic [15:0] crc_trailer;
  logic [16:0] size_sum;
  logic        is_greet;
  logic        counted;
  logic        due;
  verdict_t    verdict_nxt;

  logic [31:0] out_sum;
  logic        out_counted;
  logic        pkt_idle;

  assign out_free = !out_valid_r || out_if.ready;
  assign proc_go  = s_valid_r && (!s_last_r || out_free);
  assign pkt_end  = proc_go && s_last_r;
  assign in_if.ready = !s_valid_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s_byte_r <= in_if.rx_byte;
      s_last_r <= in_if.last_byte;
    end
  end

  // Header capture, greeting compare and CRC for the word in the input register.
  always_comb begin
    greet_ok_nxt = greet_ok_r;
    if (byte_index_r < GREET_LEN && s_byte_r != greet_char(byte_index_r[3:0])) begin
      greet_ok_nxt = 1'b0;
    end
    hdr_magic_nxt = hdr_magic_r;
    hdr_len_nxt   = hdr_len_r;
    if (byte_index_r == 16'd0) hdr_magic_nxt = {hdr_magic_r[15:8], s_byte_r};
    if (byte_index_r == 16'd1) hdr_magic_nxt = {s_byte_r, hdr_magic_r[7:0]};
    if (byte_index_r == 16'd4) hdr_len_nxt   = {hdr_len_r[15:8], s_byte_r};
    if (byte_index_r == 16'd5) hdr_len_nxt   = {s_byte_r, hdr_len_r[7:0]};
    // The two newest bytes sit in the delay line, so the trailing CRC never enters the sum.
    crc_nxt = (byte_index_r >= 16'd2) ? crc_step(crc_r, d0_r) : crc_r;
    crc_trailer = {s_byte_r, d1_r};
    byte_index_nxt = (byte_index_r != COUNT_MAX) ? byte_index_r + 16'd1 : byte_index_r;
    size_sum = {1'b0, HDR_BYTES} + {1'b0, hdr_len_nxt} + {1'b0, CRC_BYTES};
    is_greet = greet_ok_nxt && (byte_index_nxt >= GREET_LEN);
  end

  // Verdict and statistics for a packet end.
  always_comb begin
    counted        = 1'b0;
    test_phase_nxt = test_phase_r;
    if (!test_phase_r) begin
      if (is_greet) begin
        verdict_nxt    = V_ACCEPT;
        test_phase_nxt = 1'b1;
      end else begin
        verdict_nxt = V_IGNORED;
      end
    end else if (is_greet) begin
      verdict_nxt = V_DROPPED;
    end else begin
      counted = 1'b1;
      if (byte_index_nxt < HDR_BYTES + CRC_BYTES) begin
        verdict_nxt = V_SHORT;
      end else if (hdr_magic_nxt != magic_cfg_r) begin
        verdict_nxt = V_MAGIC;
      end else if (byte_index_nxt == COUNT_MAX || size_sum != {1'b0, byte_index_nxt}) begin
        verdict_nxt = V_SIZE;
      end else if (crc_trailer != crc_nxt) begin
        verdict_nxt = V_CRC;
      end else begin
        verdict_nxt = V_GOOD;
      end
    end

    total_nxt     = total_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    countdown_nxt = countdown_r;
    due           = 1'b0;
    if (counted) begin
      total_nxt = total_r + 32'd1;
      if (verdict_nxt == V_GOOD) begin
        good_nxt = good_r + 32'd1;
      end else begin
        bad_nxt = bad_r + 32'd1;
      end
      if (countdown_r <= 16'd1) begin
        due           = 1'b1;
        countdown_nxt = interval_cfg_r;
      end else begin
        countdown_nxt = countdown_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg_r    <= MAGIC_RESET;
      interval_cfg_r <= INTERVAL_RESET;
      test_phase_r   <= 1'b0;
      byte_index_r   <= 16'd0;
      crc_r          <= CRC_INIT;
      d0_r           <= 8'd0;
      d1_r           <= 8'd0;
      hdr_magic_r    <= 16'd0;
      hdr_len_r      <= 16'd0;
      greet_ok_r     <= 1'b1;
      total_r        <= 32'd0;
      good_r         <= 32'd0;
      bad_r          <= 32'd0;
      countdown_r    <= INTERVAL_RESET;
    end else begin
      if (proc_go) begin
        if (s_last_r) begin
          test_phase_r <= test_phase_nxt;
          byte_index_r <= 16'd0;
          crc_r        <= CRC_INIT;
          d0_r         <= 8'd0;
          d1_r         <= 8'd0;
          hdr_magic_r  <= 16'd0;
          hdr_len_r    <= 16'd0;
          greet_ok_r   <= 1'b1;
          total_r      <= total_nxt;
          good_r       <= good_nxt;
          bad_r        <= bad_nxt;
          countdown_r  <= countdown_nxt;
        end else begin
          byte_index_r <= byte_index_nxt;
          crc_r        <= crc_nxt;
          d0_r         <= d1_r;
          d1_r         <= s_byte_r;
          hdr_magic_r  <= hdr_magic_nxt;
          hdr_len_r    <= hdr_len_nxt;
          greet_ok_r   <= greet_ok_nxt;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_EXPECTED_MAGIC) begin
          magic_cfg_r <= cfg_wdata;
        end else begin
          interval_cfg_r <= cfg_wdata;
          countdown_r    <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pkt_end) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_end) begin
      out_verdict_r <= verdict_nxt;
      out_total_r   <= total_nxt;
      out_good_r    <= good_nxt;
      out_bad_r     <= bad_nxt;
      out_due_r     <= due;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.verdict     = out_verdict_r;
  assign out_if.total_count = out_total_r;
  assign out_if.good_count  = out_good_r;
  assign out_if.bad_count   = out_bad_r;
  assign out_if.stats_due   = out_due_r;

  assign out_sum     = out_good_r + out_bad_r;
  assign out_counted = (out_verdict_r != V_ACCEPT) && (out_verdict_r != V_IGNORED) &&
                       (out_verdict_r != V_DROPPED);
  assign pkt_idle    = (byte_index_r == 16'd0) && greet_ok_r;

  `CPC_ASSERT_NOW(a_counts_sum, out_valid_r, out_total_r == out_sum, "total is not good plus bad")
  `CPC_ASSERT_NOW(a_due_counted, out_valid_r && out_due_r, out_counted, "mark on uncounted packet")
  `CPC_ASSERT_NEXT(a_index_clear, pkt_end, pkt_idle, "packet state not cleared")
  `CPC_ASSERT_NOW(a_phase_sticky, 1'b1, !$fell(test_phase_r), "test phase left without reset")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cpc_pkg::*;

  localparam logic [95:0] GREETING          = "Hello Device";
  localparam int          GREET_CHARS       = 12;
  localparam int          MIN_FRAME         = 8;
  localparam logic [15:0] REFLECTED_POLY    = 16'h8408;
  localparam logic [15:0] CRC_SEED          = 16'hFFFF;
  localparam logic [15:0] POS_CEILING       = 16'hFFFF;
  localparam logic [15:0] MAGIC_AT_RESET    = 16'h5AA5;
  localparam logic [15:0] INTERVAL_AT_RESET = 16'd1000;
  localparam int          LONG_WORDS        = 65540;
  localparam int          DRAIN_CYCLES      = 6;
  localparam int          STALL_LIMIT       = 1000;

  typedef logic [7:0] byte_seq_t[$];

  typedef struct {
    verdict_t    verdict;
    logic [31:0] total;
    logic [31:0] good;
    logic [31:0] bad;
    logic        due;
  } pkt_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_wdata;

  cpc_in_if  in_ch ();
  cpc_out_if out_ch ();

  crc16_packet_checker_with_handshake u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the checker.
  logic        in_test_phase;
  logic [15:0] byte_pos;
  logic [15:0] frame_crc;
  logic [7:0]  crc_delay [2];
  logic [15:0] hdr_magic;
  logic [15:0] hdr_length;
  logic        greeting_ok;
  logic [31:0] n_total;
  logic [31:0] n_good;
  logic [31:0] n_bad;
  logic [15:0] due_countdown;
  logic [15:0] magic_reg;
  logic [15:0] interval_reg;

  pkt_result_t results_q[$];

  bit          no_idle;
  int          errors;
  int          words_sent;
  int          results_checked;
  int          quiet_cycles;
  int          seen_by_verdict [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    repeat (8) c = c[0] ? ((c >> 1) ^ REFLECTED_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame_state();
    byte_pos     = 16'd0;
    frame_crc    = CRC_SEED;
    crc_delay[0] = 8'h00;
    crc_delay[1] = 8'h00;
    hdr_magic    = 16'h0000;
    hdr_length   = 16'h0000;
    greeting_ok  = 1'b1;
  endfunction

  function automatic void predictor_reset();
    magic_reg     = MAGIC_AT_RESET;
    interval_reg  = INTERVAL_AT_RESET;
    due_countdown = INTERVAL_AT_RESET;
    in_test_phase = 1'b0;
    n_total       = 32'd0;
    n_good        = 32'd0;
    n_bad         = 32'd0;
    clear_frame_state();
  endfunction

  // Advances the predicted state by one accepted word and queues the verdict on a last word.
  function automatic void predict_word(input logic [7:0] b, input logic is_last);
    logic [15:0] pos;
    logic [15:0] rx_crc;
    logic        greeting;
    logic        due;
    verdict_t    v;
    pos = byte_pos;
    if (pos < GREET_CHARS && b != GREETING[95 - 8 * pos -: 8]) greeting_ok = 1'b0;
    if (pos == 16'd0) hdr_magic[7:0] = b;
    if (pos == 16'd1) hdr_magic[15:8] = b;
    if (pos == 16'd4) hdr_length[7:0] = b;
    if (pos == 16'd5) hdr_length[15:8] = b;
    // The two newest bytes sit in the delay line, so the trailing CRC never enters it.
    if (pos >= 16'd2) frame_crc = crc16_update(frame_crc, crc_delay[0]);
    rx_crc = {b, crc_delay[1]};
    crc_delay[0] = crc_delay[1];
    crc_delay[1] = b;
    if (pos != POS_CEILING) byte_pos = pos + 16'd1;
    if (!is_last) return;

    greeting = greeting_ok && byte_pos >= GREET_CHARS;
    due = 1'b0;
    if (!in_test_phase) begin
      v = greeting ? V_ACCEPT : V_IGNORED;
      if (greeting) in_test_phase = 1'b1;
    end else if (greeting) begin
      v = V_DROPPED;
    end else begin
      n_total = n_total + 32'd1;
      if (byte_pos < MIN_FRAME) begin
        v = V_SHORT;
      end else if (hdr_magic != magic_reg) begin
        v = V_MAGIC;
      end else if (byte_pos == POS_CEILING || 32'(hdr_length) + 32'd8 != 32'(byte_pos)) begin
        v = V_SIZE;
      end else if (rx_crc != frame_crc) begin
        v = V_CRC;
      end else begin
        v = V_GOOD;
      end
      if (v == V_GOOD) n_good = n_good + 32'd1;
      else n_bad = n_bad + 32'd1;
      if (due_countdown <= 16'd1) begin
        due = 1'b1;
        due_countdown = interval_reg;
      end else begin
        due_countdown = due_countdown - 16'd1;
      end
    end
    results_q.push_back('{verdict: v, total: n_total, good: n_good, bad: n_bad, due: due});
    clear_frame_state();
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Header (magic, two spare bytes, length field), payload, then the little-endian CRC.
  // A negative fill gives random header spare and payload bytes.
  function automatic byte_seq_t build_packet(input logic [15:0] magic, input int unsigned plen,
                                             input logic [15:0] len_field,
                                             input logic [15:0] crc_flip, input int fill);
    byte_seq_t   p;
    logic [15:0] crc;
    p.push_back(magic[7:0]);
    p.push_back(magic[15:8]);
    repeat (2) p.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    p.push_back(len_field[7:0]);
    p.push_back(len_field[15:8]);
    repeat (plen) p.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    crc = CRC_SEED;
    foreach (p[i]) crc = crc16_update(crc, p[i]);
    crc = crc ^ crc_flip;
    p.push_back(crc[7:0]);
    p.push_back(crc[15:8]);
    return p;
  endfunction

  function automatic byte_seq_t good_packet();
    int unsigned plen;
    plen = $urandom_range(0, 6);
    return build_packet(magic_reg, plen, 16'(plen), 16'h0000, -1);
  endfunction

  function automatic byte_seq_t greeting_packet(input int unsigned extra);
    byte_seq_t p;
    for (int i = 0; i < GREET_CHARS; i++) p.push_back(GREETING[95 - 8 * i -: 8]);
    repeat (extra) p.push_back(8'($urandom));
    return p;
  endfunction

  function automatic byte_seq_t random_bytes(input int unsigned n);
    byte_seq_t p;
    repeat (n) p.push_back(8'($urandom));
    return p;
  endfunction

  // Mostly well-formed frames, some with one broken field, plus greetings and noise.
  function automatic byte_seq_t random_packet();
    int unsigned pick;
    int unsigned plen;
    pick = $urandom_range(99);
    plen = $urandom_range(0, 8);
    if (pick < 55) return build_packet(magic_reg, plen, 16'(plen), 16'h0000, -1);
    if (pick < 62) return build_packet(16'($urandom), plen, 16'(plen), 16'h0000, -1);
    if (pick < 69) begin
      return build_packet(magic_reg, plen, 16'(plen) ^ (16'd1 << $urandom_range(15)),
                          16'h0000, -1);
    end
    if (pick < 76) return build_packet(magic_reg, plen, 16'(plen),
                                       16'd1 << $urandom_range(15), -1);
    if (pick < 84) return greeting_packet($urandom_range(0, 3));
    if (pick < 92) return random_bytes($urandom_range(1, 7));
    return random_bytes($urandom_range(8, 20));
  endfunction

  task automatic send_word(input logic [7:0] b, input logic is_last);
    if (!no_idle) begin
      while ($urandom_range(99) < 36) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.last_byte <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    predict_word(b, is_last);
  endtask

  task automatic send_packet(input byte_seq_t pkt);
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
  endtask

  // Waits until every verdict is back, then lets the pipeline settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_EXPECTED_MAGIC) begin
      magic_reg = val;
    end else begin
      interval_reg  = val;
      due_countdown = val;
    end
  endtask

  task automatic test_greeting_phase();
    byte_seq_t p;
    send_packet(random_bytes(1));
    send_packet(build_packet(magic_reg, 2, 16'd2, 16'h0000, -1));
    p = greeting_packet(0);
    p[6] = p[6] ^ 8'h20;
    send_packet(p);
    p = greeting_packet(0);
    p.delete(p.size() - 1);
    send_packet(p);
    send_packet(greeting_packet(0));
    drain_results();
  endtask

  task automatic test_frame_checks();
    byte_seq_t p;
    send_packet(greeting_packet(5));
    send_packet(build_packet(magic_reg, 4, 16'd4, 16'h0000, -1));
    send_packet(build_packet(magic_reg, 0, 16'd0, 16'h0000, 8'h00));
    send_packet(build_packet(magic_reg, 6, 16'd6, 16'h0000, 8'hFF));
    send_packet(random_bytes(1));
    send_packet(random_bytes(7));
    // Eleven greeting characters are not a greeting, so this one is checked as a frame.
    p = greeting_packet(0);
    p.delete(p.size() - 1);
    send_packet(p);
    send_packet(build_packet(~magic_reg, 3, 16'd3, 16'h0000, -1));
    send_packet(build_packet(magic_reg, 3, 16'hFFFF, 16'h0000, -1));
    send_packet(build_packet(magic_reg, 3, 16'd2, 16'h0000, -1));
    send_packet(build_packet(magic_reg, 5, 16'd5, 16'h8000, -1));
    send_packet(build_packet(magic_reg, 5, 16'd5, 16'h0001, -1));
    drain_results();
  endtask

  task automatic test_register_settings();
    write_reg(CFG_EXPECTED_MAGIC, 16'h0000);
    send_packet(build_packet(16'h0000, 2, 16'd2, 16'h0000, -1));
    send_packet(build_packet(MAGIC_AT_RESET, 2, 16'd2, 16'h0000, -1));
    drain_results();
    write_reg(CFG_EXPECTED_MAGIC, 16'hFFFF);
    write_reg(CFG_STATS_INTERVAL, 16'd1);
    repeat (3) send_packet(good_packet());
    drain_results();
    // An interval of zero marks every counted packet, like an interval of one.
    write_reg(CFG_STATS_INTERVAL, 16'd0);
    repeat (2) send_packet(good_packet());
    drain_results();
    write_reg(CFG_STATS_INTERVAL, 16'hFFFF);
    repeat (3) send_packet(good_packet());
    drain_results();
    write_reg(CFG_STATS_INTERVAL, 16'd3);
    repeat (2) send_packet(good_packet());
    drain_results();
    // Rewriting the interval restarts the countdown mid-interval.
    write_reg(CFG_STATS_INTERVAL, 16'd3);
    repeat (4) send_packet(good_packet());
    drain_results();
  endtask

  // The byte count saturates; a length field matching the saturated count must still fail.
  task automatic test_long_packet();
    send_packet(build_packet(magic_reg, LONG_WORDS - MIN_FRAME, POS_CEILING - 16'd8,
                             16'h0000, -1));
    send_packet(good_packet());
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 5; round++) begin
      write_reg(CFG_EXPECTED_MAGIC, 16'($urandom));
      write_reg(CFG_STATS_INTERVAL, 16'($urandom_range(1, 7)));
      no_idle = (round == 2);
      repeat (12) send_packet(random_packet());
      drain_results();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    pkt_result_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("testbench failed");
        $finish;
      end else if (out_ch.valid && out_ch.ready) begin
        if (results_q.size() == 0) begin
          flag_error($sformatf("result with no packet pending, verdict %s",
                               out_ch.verdict.name()));
        end else begin
          want = results_q.pop_front();
          results_checked++;
          seen_by_verdict[want.verdict]++;
          if (out_ch.verdict !== want.verdict || out_ch.total_count !== want.total ||
              out_ch.good_count !== want.good || out_ch.bad_count !== want.bad ||
              out_ch.stats_due !== want.due) begin
            flag_error($sformatf({"result %0d: expected %s total %0d good %0d bad %0d due %0b,",
                                  " got %s total %0d good %0d bad %0d due %0b"},
                                 results_checked, want.verdict.name(), want.total, want.good,
                                 want.bad, want.due, out_ch.verdict.name(),
                                 out_ch.total_count, out_ch.good_count, out_ch.bad_count,
                                 out_ch.stats_due));
          end
        end
      end
    end
    out_ch.ready <= no_idle || ($urandom_range(99) >= 36);
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_EXPECTED_MAGIC;
    cfg_wdata       <= 16'h0000;
    in_ch.valid     <= 1'b0;
    in_ch.rx_byte   <= 8'h00;
    in_ch.last_byte <= 1'b0;
    predictor_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_greeting_phase();
    test_frame_checks();
    test_register_settings();
    test_long_packet();
    test_random_traffic();
    drain_results();

    if (results_q.size() != 0) flag_error($sformatf("%0d verdicts never arrived",
                                                    results_q.size()));
    $display("Checked %0d packet verdicts from %0d words, one packet of %0d words included.",
             results_checked, words_sent, LONG_WORDS);
    $display({"Verdicts: %0d accepted, %0d ignored, %0d dropped, %0d good, %0d short,",
              " %0d magic, %0d size, %0d CRC; %0d errors."},
             seen_by_verdict[V_ACCEPT], seen_by_verdict[V_IGNORED], seen_by_verdict[V_DROPPED],
             seen_by_verdict[V_GOOD], seen_by_verdict[V_SHORT], seen_by_verdict[V_MAGIC],
             seen_by_verdict[V_SIZE], seen_by_verdict[V_CRC], errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
